// ----- rtl/sfp_pkg.sv -----
// Shared types, constants and CRC step for the sync frame parser.
package sfp_pkg;

  localparam int unsigned CNT_W         = 6;
  localparam int unsigned LENGTH_LIMIT  = 50;
  localparam int unsigned PAYLOAD_DEPTH = 64;

  localparam logic [7:0]  SYNC_FIRST  = 8'hFD;
  localparam logic [7:0]  SYNC_SECOND = 8'hFE;
  localparam logic [15:0] CRC_START   = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_HUNT,
    ST_SYNC2,
    ST_LEN,
    ST_SEND,
    ST_TARG,
    ST_MSG,
    ST_PAY,
    ST_CRCL,
    ST_CRCH,
    ST_FETCH,
    ST_EMIT
  } sfp_state_e;

  typedef struct packed {
    logic crc_seed;
    logic len_ld;
    logic snd_ld;
    logic tgt_ld;
    logic msg_ld;
    logic pay_wr;
    logic crc_extra;
    logic rd_start;
    logic rd_fetch;
    logic rd_next;
  } sfp_cmd_t;

  typedef struct packed {
    logic len_ok;
    logic len_zero;
    logic pay_done;
    logic lo_match;
    logic hi_match;
    logic rd_last;
  } sfp_status_t;

  // CRC-16/MCRF4XX, one byte
  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [7:0]  t;
    logic [15:0] t16;
    t   = b ^ crc[7:0];
    t   = t ^ {t[3:0], 4'b0000};
    t16 = {8'h00, t};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ (t16 << 3) ^ (t16 >> 4);
  endfunction

endpackage

// ----- rtl/sfp_ctrl.sv -----
// Frame parser controller: phase state machine and readout sequencing.
module sfp_ctrl
  import sfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  in_byte_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  sfp_status_t status_i,
  output sfp_cmd_t    cmd_o
);

  sfp_state_e state_q, state_d;
  logic       acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q != ST_FETCH) && (state_q != ST_EMIT);
  assign out_valid_o = (state_q == ST_EMIT);
  assign acc         = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_SYNC2: begin
        if (acc) begin
          if (in_byte_i == SYNC_SECOND) begin
            cmd_o.crc_seed = 1'b1;
            state_d        = ST_LEN;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_LEN: begin
        if (acc) begin
          if (status_i.len_ok) begin
            cmd_o.len_ld = 1'b1;
            state_d      = ST_SEND;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_SEND: begin
        if (acc) begin
          cmd_o.snd_ld = 1'b1;
          state_d      = ST_TARG;
        end
      end
      ST_TARG: begin
        if (acc) begin
          cmd_o.tgt_ld = 1'b1;
          state_d      = ST_MSG;
        end
      end
      ST_MSG: begin
        if (acc) begin
          cmd_o.msg_ld = 1'b1;
          state_d      = status_i.len_zero ? ST_CRCL : ST_PAY;
        end
      end
      ST_PAY: begin
        if (acc) begin
          cmd_o.pay_wr = 1'b1;
          if (status_i.pay_done) begin
            state_d = ST_CRCL;
          end
        end
      end
      ST_CRCL: begin
        if (acc) begin
          cmd_o.crc_extra = 1'b1;
          state_d         = status_i.lo_match ? ST_CRCH : ST_HUNT;
        end
      end
      ST_CRCH: begin
        if (acc) begin
          if (status_i.hi_match) begin
            cmd_o.rd_start = 1'b1;
            state_d        = status_i.len_zero ? ST_EMIT : ST_FETCH;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_FETCH: begin
        cmd_o.rd_fetch = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          if (status_i.len_zero || status_i.rd_last) begin
            state_d = ST_HUNT;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = ST_FETCH;
          end
        end
      end
      default: begin
        if (acc) begin
          state_d = (in_byte_i == SYNC_FIRST) ? ST_SYNC2 : ST_HUNT;
        end
      end
    endcase
  end

endmodule

// ----- rtl/sfp_dpath.sv -----
// Frame parser datapath: header registers, CRC, payload memory and result word.
module sfp_dpath
  import sfp_pkg::*;
#(
  parameter int unsigned PayloadDepth = PAYLOAD_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        in_byte_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  sfp_cmd_t          cmd_i,
  output sfp_status_t       status_o,
  output logic [7:0]        sender_o,
  output logic [7:0]        target_o,
  output logic [7:0]        message_o,
  output logic [CNT_W-1:0]  length_o,
  output logic [7:0]        payload_o,
  output logic [CNT_W-1:0]  index_o,
  output logic              has_payload_o,
  output logic              last_o
);

  localparam int unsigned AW = (PayloadDepth > 1) ? $clog2(PayloadDepth) : 1;

  logic [7:0]       extra_q;
  logic [15:0]      crc_q, crc_d, crc_x;
  logic [CNT_W-1:0] rcnt_q, rcnt_inc;
  logic [CNT_W-1:0] len_q;
  logic [7:0]       snd_q, tgt_q, msg_q;
  logic [CNT_W-1:0] ridx_q, ridx_inc;
  logic [7:0]       rdat_q;
  logic [7:0]       mem_q [PayloadDepth];
  logic             wr_in_range, rd_in_range;

  assign rcnt_inc    = rcnt_q + CNT_W'(1);
  assign ridx_inc    = ridx_q + CNT_W'(1);
  assign crc_x       = crc_step(crc_q, extra_q);
  assign wr_in_range = {1'b0, rcnt_q} < (CNT_W + 1)'(PayloadDepth);
  assign rd_in_range = {1'b0, ridx_q} < (CNT_W + 1)'(PayloadDepth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extra_q <= '0;
    end else if (cfg_we_i) begin
      extra_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    crc_d = crc_q;
    if (cmd_i.crc_seed) begin
      crc_d = CRC_START;
    end else if (cmd_i.crc_extra) begin
      crc_d = crc_x;
    end else if (cmd_i.len_ld || cmd_i.snd_ld || cmd_i.tgt_ld || cmd_i.msg_ld ||
                 cmd_i.pay_wr) begin
      crc_d = crc_step(crc_q, in_byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CRC_START;
      rcnt_q <= '0;
      len_q  <= '0;
      snd_q  <= '0;
      tgt_q  <= '0;
      msg_q  <= '0;
      ridx_q <= '0;
    end else begin
      crc_q <= crc_d;
      if (cmd_i.crc_seed) rcnt_q <= '0;
      else if (cmd_i.pay_wr) rcnt_q <= rcnt_inc;
      if (cmd_i.len_ld) len_q <= in_byte_i[CNT_W-1:0];
      if (cmd_i.snd_ld) snd_q <= in_byte_i;
      if (cmd_i.tgt_ld) tgt_q <= in_byte_i;
      if (cmd_i.msg_ld) msg_q <= in_byte_i;
      if (cmd_i.rd_start) ridx_q <= '0;
      else if (cmd_i.rd_next) ridx_q <= ridx_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pay_wr && wr_in_range) begin
      mem_q[rcnt_q[AW-1:0]] <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_fetch) begin
      rdat_q <= rd_in_range ? mem_q[ridx_q[AW-1:0]] : 8'h00;
    end
  end

  assign status_o.len_ok   = in_byte_i < 8'(LENGTH_LIMIT);
  assign status_o.len_zero = (len_q == '0);
  assign status_o.pay_done = (rcnt_inc == len_q);
  assign status_o.lo_match = (in_byte_i == crc_x[7:0]);
  assign status_o.hi_match = (in_byte_i == crc_q[15:8]);
  assign status_o.rd_last  = (ridx_inc == len_q);

  assign sender_o      = snd_q;
  assign target_o      = tgt_q;
  assign message_o     = msg_q;
  assign length_o      = len_q;
  assign has_payload_o = (len_q != '0);
  assign payload_o     = has_payload_o ? rdat_q : 8'h00;
  assign index_o       = ridx_q;
  assign last_o        = !has_payload_o || (ridx_inc == len_q);

endmodule

// ----- rtl/sync_frame_parser_crc16.sv -----
// Sync frame parser with CRC-16/MCRF4XX check, top level.
//
//   channel  dir  word
//   s_axis   in   tdata[7:0] rx_byte
//   m_axis   out  tdata[47:0] result header and payload byte, tuser has_payload,
//                 tlast last result of frame
//   cfg      in   cfg_wdata_i[7:0] crc_extra_byte
//
// One received byte is taken per cycle while the frame is being parsed.
// A good frame is read out from the payload RAM one result word at a time
// (registered RAM read, then present); header-only frames skip the RAM read.
// s_axis_tready stays low during readout. m_axis_tready low holds the word.
// Reset puts the parser into hunting; payload RAM is not cleared.
module sync_frame_parser_crc16
  import sfp_pkg::*;
#(
  parameter int unsigned PayloadDepth = PAYLOAD_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] sender_id, [15:8] target_id, [23:16] message_id, [29:24] frame_length,
  // [37:30] payload_byte, [43:38] byte_index, [47:44] zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] has_payload
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  sfp_cmd_t         cmd;
  sfp_status_t      status;
  logic [7:0]       sender, target, message, payload;
  logic [CNT_W-1:0] length, index;

  sfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sfp_dpath #(
    .PayloadDepth(PayloadDepth)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (s_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .sender_o     (sender),
    .target_o     (target),
    .message_o    (message),
    .length_o     (length),
    .payload_o    (payload),
    .index_o      (index),
    .has_payload_o(m_axis_tuser),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, index, payload, length, message, target, sender};

endmodule

// ----- verif/sync_frame_parser_crc16_tb.sv -----
// Testbench for sync_frame_parser_crc16: random and directed byte streams checked against a predictor.
module sync_frame_parser_crc16_tb;
  import sfp_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_CYC   = 10;
  localparam int unsigned TARGET_BYTES = 270;

  typedef struct packed {
    logic [7:0] sender;
    logic [7:0] target;
    logic [7:0] msg_id;
    logic [5:0] length;
    logic [7:0] pay_byte;
    logic [5:0] index;
    logic       has_pay;
    logic       last_word;
  } frame_word_t;

  typedef enum {FR_GOOD, FR_BAD_LO, FR_BAD_HI} frame_fault_e;

  class frame_scoreboard;
    sfp_state_e  phase;
    logic [5:0]  rx_count;
    logic [5:0]  decl_len;
    logic [15:0] crc;
    logic [7:0]  snd, tgt, msg;
    logic [7:0]  extra;
    logic [7:0]  pay_mem [64];
    frame_word_t expected_q[$];
    int          errors;
    int          words_ok;
    int          frames_ok;

    function new();
      phase     = ST_HUNT;
      rx_count  = '0;
      decl_len  = '0;
      crc       = CRC_START;
      snd       = '0;
      tgt       = '0;
      msg       = '0;
      extra     = '0;
      errors    = 0;
      words_ok  = 0;
      frames_ok = 0;
    endfunction

    // CRC-16/MCRF4XX, bitwise with the reflected polynomial
    static function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
      return r;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_byte(logic [7:0] b);
      frame_word_t w;
      case (phase)
        ST_SYNC2: begin
          if (b == SYNC_SECOND) begin
            rx_count = '0;
            crc      = CRC_START;
            phase    = ST_LEN;
          end else begin
            phase = ST_HUNT;
          end
        end
        ST_LEN: begin
          if (b < LENGTH_LIMIT && b < 64) begin
            decl_len = b[5:0];
            crc      = crc_update(crc, b);
            phase    = ST_SEND;
          end else begin
            phase = ST_HUNT;
          end
        end
        ST_SEND: begin
          snd   = b;
          crc   = crc_update(crc, b);
          phase = ST_TARG;
        end
        ST_TARG: begin
          tgt   = b;
          crc   = crc_update(crc, b);
          phase = ST_MSG;
        end
        ST_MSG: begin
          msg   = b;
          crc   = crc_update(crc, b);
          phase = (decl_len == 0) ? ST_CRCL : ST_PAY;
        end
        ST_PAY: begin
          crc = crc_update(crc, b);
          if (rx_count < PAYLOAD_DEPTH) pay_mem[rx_count] = b;
          rx_count = rx_count + 6'd1;
          if (rx_count == decl_len) phase = ST_CRCL;
        end
        ST_CRCL: begin
          crc   = crc_update(crc, extra);
          phase = (b == crc[7:0]) ? ST_CRCH : ST_HUNT;
        end
        ST_CRCH: begin
          if (b == crc[15:8]) begin
            frames_ok++;
            w.sender = snd;
            w.target = tgt;
            w.msg_id = msg;
            w.length = decl_len;
            if (decl_len == 0) begin
              w.pay_byte  = '0;
              w.index     = '0;
              w.has_pay   = 1'b0;
              w.last_word = 1'b1;
              expected_q.push_back(w);
            end else begin
              for (int i = 0; i < decl_len; i++) begin
                w.pay_byte  = (i < PAYLOAD_DEPTH) ? pay_mem[i] : 8'h00;
                w.index     = 6'(i);
                w.has_pay   = 1'b1;
                w.last_word = (i == decl_len - 1);
                expected_q.push_back(w);
              end
            end
          end
          phase = ST_HUNT;
        end
        default: phase = (b == SYNC_FIRST) ? ST_SYNC2 : ST_HUNT;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("ERROR: %s", what);
      errors++;
    endtask

    task cmp_field(string name, int unsigned got, int unsigned want);
      if (got != want) report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    task check_word(logic [47:0] d, logic user, logic lst);
      frame_word_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result word 0x%012h", d));
        return;
      end
      e = expected_q.pop_front();
      cmp_field("sender_id", d[7:0], e.sender);
      cmp_field("target_id", d[15:8], e.target);
      cmp_field("message_id", d[23:16], e.msg_id);
      cmp_field("frame_length", d[29:24], e.length);
      cmp_field("payload_byte", d[37:30], e.pay_byte);
      cmp_field("byte_index", d[43:38], e.index);
      cmp_field("tdata pad", d[47:44], 0);
      cmp_field("has_payload", user, e.has_pay);
      cmp_field("last", lst, e.last_word);
      words_ok++;
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;

  frame_scoreboard sb = new();

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int bytes_sent;
  int settings_used;
  int holds_done;

  sync_frame_parser_crc16 dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input int len, input logic [7:0] snd, input logic [7:0] tgt,
                            input logic [7:0] msg, input frame_fault_e fault,
                            input logic [7:0] fill[$]);
    logic [15:0] c;
    logic [7:0]  pb;
    logic [7:0]  frame_q[$];
    frame_q = {SYNC_FIRST, SYNC_SECOND, 8'(len), snd, tgt, msg};
    c = CRC_START;
    for (int i = 2; i < 6; i++) c = frame_scoreboard::crc_update(c, frame_q[i]);
    for (int i = 0; i < len; i++) begin
      pb = (i < fill.size()) ? fill[i] : 8'($urandom);
      frame_q.push_back(pb);
      c = frame_scoreboard::crc_update(c, pb);
    end
    c = frame_scoreboard::crc_update(c, sb.extra);
    if (fault == FR_BAD_LO) c[7:0]  = c[7:0] ^ 8'($urandom_range(1, 255));
    if (fault == FR_BAD_HI) c[15:8] = c[15:8] ^ 8'($urandom_range(1, 255));
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  task automatic random_item();
    int           pick;
    int           len;
    frame_fault_e fault;
    logic [7:0]   no_fill[$];
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
    end else if (pick < 12) begin
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(8'($urandom_range(LENGTH_LIMIT, 255)));
    end else if (pick < 15) begin
      send_byte(SYNC_FIRST);
      send_byte(8'($urandom_range(0, 253)));
    end else begin
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(45, LENGTH_LIMIT - 1);
        1, 2:    len = $urandom_range(9, 20);
        default: len = $urandom_range(0, 8);
      endcase
      fault = (pick < 25) ? FR_BAD_LO : (pick < 33) ? FR_BAD_HI : FR_GOOD;
      send_frame(len, 8'($urandom), 8'($urandom), 8'($urandom), fault, no_fill);
    end
  endtask

  // parser back to hunting, all results out, then the register write
  task automatic write_extra(input logic [7:0] v);
    while (sb.phase != ST_HUNT) send_byte(8'h00);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.extra = v;
    settings_used++;
  endtask

  initial begin
    logic [7:0] fill[$];
    logic [7:0] no_fill[$];
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: sync faults, length limit, empty frame, CRC faults, sync bytes as payload
    write_extra(8'h00);
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'(LENGTH_LIMIT));
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'hFF);
    send_frame(0, 8'hFF, 8'h00, 8'hFF, FR_GOOD, no_fill);
    fill = {8'hFF};
    send_frame(1, 8'h00, 8'hFF, 8'h00, FR_BAD_LO, fill);
    fill = {8'h00};
    send_frame(1, 8'h5A, 8'hA5, 8'h3C, FR_BAD_HI, fill);
    fill = {SYNC_FIRST, SYNC_SECOND};
    send_frame(2, 8'h00, 8'hFF, 8'h00, FR_GOOD, fill);

    write_extra(8'hFF);
    send_frame(LENGTH_LIMIT - 1, 8'($urandom), 8'($urandom), 8'($urandom), FR_GOOD, no_fill);
    while (bytes_sent < 110) random_item();

    // long receiver hold-off so the readout backs up into the input
    write_extra(8'($urandom));
    hold_req = 1'b1;
    while (bytes_sent < 190) random_item();

    write_extra(8'($urandom_range(1, 254)));
    idle_on = 1'b0;
    send_frame(LENGTH_LIMIT - 1, 8'($urandom), 8'($urandom), 8'($urandom), FR_GOOD, no_fill);
    while (bytes_sent < TARGET_BYTES) random_item();
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d bytes under %0d CRC extra settings and %0d long hold-off(s).",
             bytes_sent, settings_used, holds_done);
    $display("%0d frames passed the CRC, %0d result words checked, %0d mismatches.",
             sb.frames_ok, sb.words_ok, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d result words still expected.", sb.pending());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sync_frame_parser_crc16.f -----
rtl/sfp_pkg.sv
rtl/sfp_ctrl.sv
rtl/sfp_dpath.sv
rtl/sync_frame_parser_crc16.sv
verif/sync_frame_parser_crc16_tb.sv
